FILE: rtl/glyph_table_format_parser_core_assert.svh
// Assertion macros for the glyph table format parser.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef GLYPH_TABLE_FORMAT_PARSER_CORE_ASSERT_SVH
`define GLYPH_TABLE_FORMAT_PARSER_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication.
`define GTFP_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication.
`define GTFP_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define GTFP_ASSERT_IMP(lbl, ante, cons, msg)
`define GTFP_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

FILE: rtl/gtfp_pkg.sv
`timescale 1ns / 1ps
package gtfp_pkg;

	// Default framing sizes.
	localparam int HEADER_BYTES_DEF = 28;
	localparam int RECORD_BYTES_DEF = 12;

	// Bytes of the header and of a record that carry fields.
	localparam int HDR_FIELD_BYTES = 28;
	localparam int REC_FIELD_BYTES = 9;

	// Byte position counter and payload size widths.
	localparam int POS_W = 22;
	localparam int SIZE_W = 23;
	localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

	// Configuration port.
	localparam int ADDR_W = 3;
	localparam logic REG_MAGIC = 1'b0;
	localparam logic REG_VERSION = 1'b1;

	// Header field byte offsets.
	localparam int OFS_MAGIC_LO = 0;
	localparam int OFS_MAGIC_HI = 2;
	localparam int OFS_VERSION = 4;
	localparam int OFS_FLAGS = 6;
	localparam int OFS_ATLAS_W = 8;
	localparam int OFS_ATLAS_H = 10;
	localparam int OFS_LINE_H = 12;
	localparam int OFS_BASELINE = 14;
	localparam int OFS_SPACE_ADV = 16;
	localparam int OFS_FIRST_CODE = 18;
	localparam int OFS_GLYPH_CNT = 20;
	localparam int OFS_MISSING = 22;
	localparam int OFS_CELL_CNT = 24;
	localparam int OFS_CELL_OFS = 26;

	// Record kinds.
	localparam logic [1:0] KIND_HEADER = 2'd0;
	localparam logic [1:0] KIND_GLYPH = 2'd1;
	localparam logic [1:0] KIND_CELL = 2'd2;
	localparam logic [1:0] KIND_STATUS = 2'd3;

	// Parser phases.
	localparam logic [1:0] PH_HEADER = 2'd0;
	localparam logic [1:0] PH_GLYPHS = 2'd1;
	localparam logic [1:0] PH_CELLS = 2'd2;
	localparam logic [1:0] PH_DONE = 2'd3;

	// Status codes.
	localparam logic [3:0] ST_OK = 4'd0;
	localparam logic [3:0] ST_SHORT_HEADER = 4'd1;
	localparam logic [3:0] ST_BAD_MAGIC = 4'd2;
	localparam logic [3:0] ST_BAD_VERSION = 4'd3;
	localparam logic [3:0] ST_TRUNCATED = 4'd4;
	localparam logic [3:0] ST_CELL_OFS = 4'd5;
	localparam logic [3:0] ST_SUBST_RANGE = 4'd6;
	localparam logic [3:0] ST_ZERO_DIM = 4'd7;
	localparam logic [3:0] ST_GLYPH_BOUNDS = 4'd8;
	localparam logic [3:0] ST_CELL_BOUNDS = 4'd9;

	// One decoded record (header, glyph or cell).
	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] index;
		logic [15:0] pos_u;
		logic [15:0] pos_v;
		logic [7:0]  box_width;
		logic [7:0]  box_height;
		logic [7:0]  bearing_x;
		logic [7:0]  bearing_y;
		logic [7:0]  advance;
		logic [63:0] header_word;
	} rec_t;

	// Everything one payload byte produces: an optional record and an optional status.
	typedef struct packed {
		logic       rec_v;
		logic       st_v;
		rec_t       rec;
		logic [3:0] status;
	} res_pair_t;

	// Parser state seen by the top level.
	typedef struct packed {
		logic       pos_zero;
		logic [1:0] phase;
	} parse_state_t;

	// Little-endian 16-bit field from two bytes.
	function automatic logic [15:0] le16(input logic [7:0] lo, input logic [7:0] hi);
		return {hi, lo};
	endfunction

endpackage

FILE: rtl/gtfp_parse.sv
`timescale 1ns / 1ps
module gtfp_parse #(
	parameter int HEADER_BYTES = gtfp_pkg::HEADER_BYTES_DEF,
	parameter int RECORD_BYTES = gtfp_pkg::RECORD_BYTES_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   accept,
	input  logic [7:0]             payload_byte,
	input  logic                   final_byte,
	input  logic [31:0]            expected_magic,
	input  logic [15:0]            expected_version,
	output gtfp_pkg::res_pair_t    result,
	output gtfp_pkg::parse_state_t pstate
);
	import gtfp_pkg::*;

	localparam int OFF_W = $clog2(RECORD_BYTES);
	localparam logic [POS_W-1:0] HDR_LAST = POS_W'(HEADER_BYTES - 1);
	localparam logic [OFF_W-1:0] REC_LAST = OFF_W'(RECORD_BYTES - 1);
	localparam logic [SIZE_W-1:0] HDR_SIZE = SIZE_W'(HEADER_BYTES);
	localparam logic [SIZE_W-1:0] REC_SIZE = SIZE_W'(RECORD_BYTES);

	logic [POS_W-1:0] pos_q, pos_d;
	logic [1:0]       phase_q, phase_d;
	logic [15:0]      rnum_q, rnum_d;
	logic [OFF_W-1:0] off_q, off_d;
	logic [3:0]       ferr_q, ferr_d;
	logic [7:0]       hdr_q [HDR_FIELD_BYTES];
	logic [7:0]       rec_q [REC_FIELD_BYTES];
	logic [7:0]       hdr_n [HDR_FIELD_BYTES];
	logic [7:0]       rec_n [REC_FIELD_BYTES];

	logic             in_hdr, in_tab, is_cell, hdr_done, rec_done, oob;
	logic [15:0]      atlas_w, atlas_h, glyph_cnt, cell_cnt, rnum_inc;
	logic [15:0]      u, v;
	logic [SIZE_W-1:0] size, tab_end, tab_expect;
	logic [31:0]      magic;
	logic [3:0]       status;

	assign in_hdr = (phase_q == PH_HEADER);
	assign in_tab = (phase_q == PH_GLYPHS) || (phase_q == PH_CELLS);
	assign is_cell = (phase_q == PH_CELLS);

	// Store views with the current byte merged in.
	always_comb begin
		for (int i = 0; i < HDR_FIELD_BYTES; i++) begin
			hdr_n[i] = (in_hdr && pos_q == POS_W'(i)) ? payload_byte : hdr_q[i];
		end
		for (int i = 0; i < REC_FIELD_BYTES; i++) begin
			rec_n[i] = (in_tab && off_q == OFF_W'(i)) ? payload_byte : rec_q[i];
		end
	end

	assign atlas_w = le16(hdr_n[OFS_ATLAS_W], hdr_n[OFS_ATLAS_W+1]);
	assign atlas_h = le16(hdr_n[OFS_ATLAS_H], hdr_n[OFS_ATLAS_H+1]);
	assign glyph_cnt = le16(hdr_n[OFS_GLYPH_CNT], hdr_n[OFS_GLYPH_CNT+1]);
	assign cell_cnt = le16(hdr_n[OFS_CELL_CNT], hdr_n[OFS_CELL_CNT+1]);
	assign u = le16(rec_n[0], rec_n[1]);
	assign v = le16(rec_n[2], rec_n[3]);

	assign hdr_done = in_hdr && (pos_q == HDR_LAST);
	assign rec_done = in_tab && (off_q == REC_LAST);
	assign rnum_inc = rnum_q + 16'd1;

	// Bounds check of a record against the atlas.
	assign oob = ({1'b0, u} + {9'd0, rec_n[4]} > {1'b0, atlas_w})
		|| ({1'b0, v} + {9'd0, rec_n[5]} > {1'b0, atlas_h});

	// Next state for one accepted byte.
	always_comb begin
		phase_d = phase_q;
		rnum_d = rnum_q;
		off_d = off_q;
		ferr_d = ferr_q;
		if (hdr_done) begin
			rnum_d = '0;
			off_d = '0;
			if (glyph_cnt != 16'd0) begin
				phase_d = PH_GLYPHS;
			end else if (cell_cnt != 16'd0) begin
				phase_d = PH_CELLS;
			end else begin
				phase_d = PH_DONE;
			end
		end else if (rec_done) begin
			off_d = '0;
			rnum_d = rnum_inc;
			if (oob && ferr_q == ST_OK) begin
				ferr_d = is_cell ? ST_CELL_BOUNDS : ST_GLYPH_BOUNDS;
			end
			if (!is_cell && rnum_inc == glyph_cnt) begin
				rnum_d = '0;
				phase_d = (cell_cnt != 16'd0) ? PH_CELLS : PH_DONE;
			end else if (is_cell && rnum_inc == cell_cnt) begin
				phase_d = PH_DONE;
			end
		end else if (in_tab) begin
			off_d = off_q + OFF_W'(1);
		end
		pos_d = (pos_q != POS_MAX) ? pos_q + POS_W'(1) : pos_q;
	end

	// Final status in check priority order.
	assign size = {1'b0, pos_q} + SIZE_W'(1);
	assign magic = {le16(hdr_n[OFS_MAGIC_HI], hdr_n[OFS_MAGIC_HI+1]),
		le16(hdr_n[OFS_MAGIC_LO], hdr_n[OFS_MAGIC_LO+1])};
	assign tab_end = HDR_SIZE + SIZE_W'(glyph_cnt) * REC_SIZE;
	assign tab_expect = tab_end + SIZE_W'(cell_cnt) * REC_SIZE;

	always_comb begin
		if (size < HDR_SIZE) begin
			status = ST_SHORT_HEADER;
		end else if (magic != expected_magic) begin
			status = ST_BAD_MAGIC;
		end else if (le16(hdr_n[OFS_VERSION], hdr_n[OFS_VERSION+1]) != expected_version) begin
			status = ST_BAD_VERSION;
		end else if (glyph_cnt == 16'd0 || size < tab_expect) begin
			status = ST_TRUNCATED;
		end else if (SIZE_W'(le16(hdr_n[OFS_CELL_OFS], hdr_n[OFS_CELL_OFS+1])) != tab_end) begin
			status = ST_CELL_OFS;
		end else if (le16(hdr_n[OFS_MISSING], hdr_n[OFS_MISSING+1]) >= glyph_cnt) begin
			status = ST_SUBST_RANGE;
		end else if (le16(hdr_n[OFS_LINE_H], hdr_n[OFS_LINE_H+1]) == 16'd0
			|| atlas_w == 16'd0 || atlas_h == 16'd0) begin
			status = ST_ZERO_DIM;
		end else begin
			status = ferr_d;
		end
	end

	// Results of this byte.
	always_comb begin
		result = '0;
		result.rec_v = hdr_done || rec_done;
		result.st_v = final_byte;
		result.status = status;
		if (hdr_done) begin
			result.rec.kind = KIND_HEADER;
			result.rec.index = glyph_cnt;
			result.rec.pos_u = atlas_w;
			result.rec.pos_v = atlas_h;
			result.rec.box_width = hdr_n[OFS_LINE_H];
			result.rec.box_height = hdr_n[OFS_BASELINE];
			result.rec.advance = hdr_n[OFS_SPACE_ADV];
			result.rec.header_word = {8'd0, hdr_n[OFS_FLAGS], cell_cnt,
				le16(hdr_n[OFS_MISSING], hdr_n[OFS_MISSING+1]),
				le16(hdr_n[OFS_FIRST_CODE], hdr_n[OFS_FIRST_CODE+1])};
		end else begin
			result.rec.kind = is_cell ? KIND_CELL : KIND_GLYPH;
			result.rec.index = rnum_q;
			result.rec.pos_u = u;
			result.rec.pos_v = v;
			result.rec.box_width = rec_n[4];
			result.rec.box_height = rec_n[5];
			result.rec.bearing_x = rec_n[6];
			result.rec.bearing_y = rec_n[7];
			result.rec.advance = rec_n[8];
		end
	end

	// Control state; a final byte returns the parser to its start.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			phase_q <= PH_HEADER;
			rnum_q <= '0;
			off_q <= '0;
			ferr_q <= ST_OK;
		end else if (accept) begin
			if (final_byte) begin
				pos_q <= '0;
				phase_q <= PH_HEADER;
				rnum_q <= '0;
				off_q <= '0;
				ferr_q <= ST_OK;
			end else begin
				pos_q <= pos_d;
				phase_q <= phase_d;
				rnum_q <= rnum_d;
				off_q <= off_d;
				ferr_q <= ferr_d;
			end
		end
	end

	// Header and record byte stores.
	always_ff @(posedge clk) begin
		if (accept) begin
			for (int i = 0; i < HDR_FIELD_BYTES; i++) begin
				hdr_q[i] <= hdr_n[i];
			end
			for (int i = 0; i < REC_FIELD_BYTES; i++) begin
				rec_q[i] <= rec_n[i];
			end
		end
	end

	assign pstate.pos_zero = (pos_q == '0);
	assign pstate.phase = phase_q;

endmodule

FILE: rtl/gtfp_outq.sv
`timescale 1ns / 1ps
module gtfp_outq (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  gtfp_pkg::res_pair_t push_data,
	output logic                not_full,
	output logic                out_valid,
	input  logic                out_ready,
	output gtfp_pkg::rec_t      out_rec,
	output logic [3:0]          out_status,
	output logic                out_last
);
	import gtfp_pkg::*;

	res_pair_t  slot_q [2];
	res_pair_t  head;
	logic [1:0] cnt_q;
	logic       wr_q, rd_q;
	logic       beat, split, pop;

	assign head = slot_q[rd_q];
	assign out_valid = (cnt_q != 2'd0);
	assign not_full = (cnt_q != 2'd2);
	assign beat = out_valid && out_ready;
	// A pair holding both a record and a status leaves in two beats.
	assign split = head.rec_v && head.st_v;
	assign pop = beat && !split;

	// The record goes first, then the status.
	always_comb begin
		out_rec = '0;
		out_status = ST_OK;
		out_last = 1'b0;
		if (head.rec_v) begin
			out_rec = head.rec;
		end else begin
			out_rec.kind = KIND_STATUS;
			out_status = head.status;
			out_last = 1'b1;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			wr_q <= 1'b0;
			rd_q <= 1'b0;
		end else begin
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
		end
	end

	// Slot payloads.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_data;
		end
		if (beat && split) begin
			slot_q[rd_q].rec_v <= 1'b0;
		end
	end

endmodule

FILE: rtl/glyph_table_format_parser_core.sv
`timescale 1ns / 1ps
// Baked font payload parser: takes one payload byte per cycle on the s_ stream (tlast on the
// final byte) while the result queue has room, emits a header record once the header is
// complete, one record per glyph and per cell entry, and a status record with tlast on the final
// byte. Every byte is parsed in the cycle it is accepted by a counter, the byte stores and
// compares, and its results go into a two-entry result queue; a full queue stalls the input. The
// byte that ends a payload while also completing a record yields two records and holds the
// output for two beats. There is no clearing pass after reset. Records already emitted are valid
// only if the following status is zero. Registers expected_magic (address 0) and expected_version
// (address 4) must be written over the APB port while the stream is idle; this is not enforced.
module glyph_table_format_parser_core #(
	parameter int HEADER_BYTES = gtfp_pkg::HEADER_BYTES_DEF,
	parameter int RECORD_BYTES = gtfp_pkg::RECORD_BYTES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [7:0]                  s_tdata,   // payload_byte[7:0]
	input  logic                        s_tlast,   // final_byte
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// index[15:0], pos_u[31:16], pos_v[47:32], box_width[55:48], box_height[63:56],
	// bearing_x[71:64], bearing_y[79:72], advance[87:80], header_word[151:88],
	// status[155:152], zero[159:156]
	output logic [159:0]                m_tdata,
	output logic [1:0]                  m_tuser,   // kind[1:0]
	output logic                        m_tlast,   // end_of_payload
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [gtfp_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);
	import gtfp_pkg::*;

	`include "glyph_table_format_parser_core_assert.svh"

	logic [31:0]  magic_q;
	logic [15:0]  version_q;
	logic         accept;
	res_pair_t    result;
	parse_state_t pstate;
	rec_t         out_rec;
	logic [3:0]   out_status;

	// Configuration registers.
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_q <= '0;
			version_q <= '0;
		end else if (psel && penable && pwrite && pready) begin
			case (paddr[2])
				REG_MAGIC: magic_q <= pwdata;
				REG_VERSION: version_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_MAGIC: prdata = magic_q;
			REG_VERSION: prdata = {16'd0, version_q};
			default: prdata = '0;
		endcase
	end

	// Byte parser.
	assign accept = s_tvalid && s_tready;

	gtfp_parse #(
		.HEADER_BYTES(HEADER_BYTES),
		.RECORD_BYTES(RECORD_BYTES)
	) u_parse (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.payload_byte(s_tdata),
		.final_byte(s_tlast),
		.expected_magic(magic_q),
		.expected_version(version_q),
		.result(result),
		.pstate(pstate)
	);

	// Result queue.
	gtfp_outq u_outq (
		.clk(clk),
		.arst_n(arst_n),
		.push(accept && (result.rec_v || result.st_v)),
		.push_data(result),
		.not_full(s_tready),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_rec(out_rec),
		.out_status(out_status),
		.out_last(m_tlast)
	);

	// Output beat packing.
	assign m_tuser = out_rec.kind;
	assign m_tdata = {4'd0, out_status, out_rec.header_word, out_rec.advance,
		out_rec.bearing_y, out_rec.bearing_x, out_rec.box_height, out_rec.box_width,
		out_rec.pos_v, out_rec.pos_u, out_rec.index};

	// Only the status beat closes a payload.
	`GTFP_ASSERT_IMP(a_last_is_status, m_tvalid, (m_tuser == KIND_STATUS) == m_tlast, "tlast and status kind disagree")
	// Backpressure only comes from a full queue, which always offers a beat.
	`GTFP_ASSERT_IMP(a_stall_has_output, !s_tready, m_tvalid, "input stalled with no output beat")
	// A final byte restarts the parser.
	`GTFP_ASSERT_NXT(a_final_restarts, accept && s_tlast, pstate.pos_zero && (pstate.phase == PH_HEADER), "parser not restarted after final byte")

endmodule
